### hdl/infix_expression_lexer_unit_defines.svh
// Assertion macros shared by the lexer RTL.
// Needs clk and rst_n in the scope where a macro is used.
`ifndef INFIX_EXPRESSION_LEXER_UNIT_DEFINES_SVH
`define INFIX_EXPRESSION_LEXER_UNIT_DEFINES_SVH

`ifndef NO_ASSERTIONS
// Property must hold at every clock edge out of reset
`define LEXU_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Condition must never be true out of reset
`define LEXU_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define LEXU_ASSERT(lbl, prop, msg)
`define LEXU_NEVER(lbl, cond, msg)
`endif

`endif

### hdl/lexu_pkg.sv
// Shared types, token codes, character codes and word table of the lexer.
// Used by the front, queue, back and top level modules.
package lexu_pkg;

  // Word buffer, result list and queue sizing
  localparam int WORD_MAX = 4;
  localparam int LEN_W    = $clog2(WORD_MAX + 1);
  localparam int CMP_N    = (WORD_MAX < 4) ? WORD_MAX : 4;
  localparam int RES_MAX  = 4;
  localparam int CNT_W    = $clog2(RES_MAX + 1);
  localparam int RIDX_W   = $clog2(RES_MAX);
  localparam int QDEPTH   = 4;
  localparam int QAW      = $clog2(QDEPTH);
  localparam int QCNT_W   = $clog2(QDEPTH + 1);

  // Token codes
  typedef enum logic [4:0] {
    TOK_SIN    = 5'd0,
    TOK_COS    = 5'd1,
    TOK_TAN    = 5'd2,
    TOK_ACOS   = 5'd3,
    TOK_ASIN   = 5'd4,
    TOK_ATAN   = 5'd5,
    TOK_SQRT   = 5'd6,
    TOK_LN     = 5'd7,
    TOK_LOG    = 5'd8,
    TOK_RPAR   = 5'd9,
    TOK_LPAR   = 5'd10,
    TOK_MOD    = 5'd11,
    TOK_ADD    = 5'd12,
    TOK_SUB    = 5'd13,
    TOK_MUL    = 5'd14,
    TOK_DIV    = 5'd15,
    TOK_POW    = 5'd16,
    TOK_UPLUS  = 5'd17,
    TOK_UMINUS = 5'd18,
    TOK_X      = 5'd19,
    TOK_NUM    = 5'd20,
    TOK_ERR    = 5'd21
  } tok_t;

  // Class of the previous token, one-hot
  typedef enum logic [4:0] {
    CLS_NONE    = 5'b00001,
    CLS_OPERAND = 5'b00010,
    CLS_CLOSE   = 5'b00100,
    CLS_OPEN    = 5'b01000,
    CLS_OTHER   = 5'b10000
  } cls_t;

  // Character codes
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_LPAR  = 8'h28;
  localparam logic [7:0] CH_RPAR  = 8'h29;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_UPE   = 8'h45;
  localparam logic [7:0] CH_CARET = 8'h5E;
  localparam logic [7:0] CH_LOWE  = 8'h65;
  localparam logic [7:0] CH_X     = 8'h78;

  // Word table: letters padded with zero, and length
  localparam int WORD_N       = 10;
  localparam int WORD_MOD_IDX = 9;
  localparam logic [7:0] WORD_TAB [WORD_N][4] = '{
    '{8'h73, 8'h69, 8'h6E, 8'h00},  // sin
    '{8'h63, 8'h6F, 8'h73, 8'h00},  // cos
    '{8'h74, 8'h61, 8'h6E, 8'h00},  // tan
    '{8'h61, 8'h63, 8'h6F, 8'h73},  // acos
    '{8'h61, 8'h73, 8'h69, 8'h6E},  // asin
    '{8'h61, 8'h74, 8'h61, 8'h6E},  // atan
    '{8'h73, 8'h71, 8'h72, 8'h74},  // sqrt
    '{8'h6C, 8'h6E, 8'h00, 8'h00},  // ln
    '{8'h6C, 8'h6F, 8'h67, 8'h00},  // log
    '{8'h6D, 8'h6F, 8'h64, 8'h00}   // mod
  };
  localparam int WORD_LEN [WORD_N] = '{3, 3, 3, 4, 4, 4, 4, 2, 3, 3};

  // One result
  typedef struct packed {
    tok_t       tok;
    logic [7:0] ch;
    logic       nend;
  } res_t;

  // Results caused by one input item
  typedef struct packed {
    res_t [RES_MAX-1:0] res;
    logic [CNT_W-1:0]   cnt;
  } entry_t;

  // Queue status seen by both sides
  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

endpackage

### hdl/lexu_front.sv
// Front end: accepts characters, tracks word/number/class state and builds
// the result list of each character. Depends on lexu_pkg.
`include "infix_expression_lexer_unit_defines.svh"

module lexu_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [7:0]        in_tdata,   // [7:0] character
  input  lexu_pkg::qstat_t  qstat,
  output logic              push,
  output lexu_pkg::entry_t  push_entry
);
  import lexu_pkg::*;

  logic [7:0]       word_chars_r [WORD_MAX];
  logic [7:0]       word_chars_nxt [WORD_MAX];
  logic [LEN_W-1:0] word_len_r, word_len_nxt;
  logic             word_ovf_r, word_ovf_nxt;
  logic [7:0]       held_char_r, held_char_nxt;
  logic             held_valid_r, held_valid_nxt;
  cls_t             prev_r, prev_nxt;

  logic       accept;
  logic [7:0] c;
  logic       is_num, is_sym, is_word;
  logic       found_ok;
  logic [3:0] found_idx;
  logic       do_resolve;
  cls_t       prev_mid;
  entry_t     ent;

  assign c         = in_tdata;
  assign in_tready = !qstat.full;
  assign accept    = in_tvalid && in_tready;

  // Classify the character
  always_comb begin
    is_num  = (c >= CH_ZERO && c <= CH_NINE) || c == CH_DOT || c == CH_UPE || c == CH_LOWE;
    is_sym  = c == CH_PLUS || c == CH_MINUS || c == CH_LPAR || c == CH_RPAR ||
              c == CH_CARET || c == CH_STAR || c == CH_SLASH;
    is_word = c != CH_NUL && c != CH_SPACE && c != CH_X && !is_num && !is_sym;
  end

  // Look up the pending word in the table
  always_comb begin
    logic same;
    found_ok  = 1'b0;
    found_idx = '0;
    for (int i = WORD_N - 1; i >= 0; i--) begin
      same = (int'(word_len_r) == WORD_LEN[i]);
      for (int k = 0; k < CMP_N; k++) begin
        if (word_chars_r[k] != WORD_TAB[i][k]) same = 1'b0;
      end
      if (same && !word_ovf_r) begin
        found_ok  = 1'b1;
        found_idx = 4'(i);
      end
    end
  end

  assign do_resolve = !is_word && (word_len_r != '0 || word_ovf_r);
  assign prev_mid   = do_resolve ? CLS_OTHER : prev_r;

  // Build the result list: number end, word (with multiply), multiply before '(' or x, character token
  always_comb begin
    res_t             cand [5];
    logic             cand_en [5];
    logic [CNT_W-1:0] n;
    for (int i = 0; i < 5; i++) begin
      cand[i]    = '{tok: TOK_ERR, ch: 8'h00, nend: 1'b0};
      cand_en[i] = 1'b0;
    end
    n = '0;

    // Held number closes on a non-number character
    cand[0]    = '{tok: TOK_NUM, ch: held_char_r, nend: 1'b1};
    cand_en[0] = !is_num && held_valid_r;

    // Multiply before a function word
    cand[1].tok = TOK_MUL;
    cand_en[1]  = do_resolve && found_ok && found_idx != 4'(WORD_MOD_IDX) &&
                  (prev_r == CLS_OPERAND || prev_r == CLS_CLOSE);

    // Word token
    cand_en[2] = do_resolve;
    if (!found_ok) cand[2].tok = TOK_ERR;
    else if (found_idx == 4'(WORD_MOD_IDX)) cand[2].tok = TOK_MOD;
    else cand[2].tok = tok_t'({1'b0, found_idx});

    // Multiply before '(' or x
    cand[3].tok = TOK_MUL;
    cand_en[3]  = (c == CH_LPAR || c == CH_X) &&
                  (prev_mid == CLS_OPERAND || prev_mid == CLS_CLOSE);

    // Token of the character itself
    cand_en[4] = 1'b1;
    if (is_num) begin
      cand[4]    = '{tok: TOK_NUM, ch: held_char_r, nend: 1'b0};
      cand_en[4] = held_valid_r;
    end else if (c == CH_LPAR) begin
      cand[4].tok = TOK_LPAR;
    end else if (c == CH_RPAR) begin
      cand[4].tok = TOK_RPAR;
    end else if (c == CH_PLUS) begin
      cand[4].tok = (prev_mid == CLS_NONE || prev_mid == CLS_OPEN) ? TOK_UPLUS : TOK_ADD;
    end else if (c == CH_MINUS) begin
      cand[4].tok = (prev_mid == CLS_NONE || prev_mid == CLS_OPEN) ? TOK_UMINUS : TOK_SUB;
    end else if (c == CH_STAR) begin
      cand[4].tok = TOK_MUL;
    end else if (c == CH_SLASH) begin
      cand[4].tok = TOK_DIV;
    end else if (c == CH_CARET) begin
      cand[4].tok = TOK_POW;
    end else if (c == CH_X) begin
      cand[4].tok = TOK_X;
    end else begin
      cand_en[4] = 1'b0;
    end

    // Pack enabled candidates in order
    ent.res = '0;
    for (int i = 0; i < 5; i++) begin
      if (cand_en[i] && n < CNT_W'(RES_MAX)) begin
        ent.res[n[RIDX_W-1:0]] = cand[i];
        n = n + CNT_W'(1);
      end
    end
    ent.cnt = n;
  end

  assign push       = accept && ent.cnt != '0;
  assign push_entry = ent;

  // Next state
  always_comb begin
    held_valid_nxt = is_num;
    held_char_nxt  = is_num ? c : 8'h00;
    word_chars_nxt = word_chars_r;
    word_len_nxt   = word_len_r;
    word_ovf_nxt   = word_ovf_r;
    if (do_resolve) begin
      for (int k = 0; k < WORD_MAX; k++) word_chars_nxt[k] = 8'h00;
      word_len_nxt = '0;
      word_ovf_nxt = 1'b0;
    end else if (is_word) begin
      if (word_len_r < LEN_W'(WORD_MAX)) begin
        for (int k = 0; k < WORD_MAX; k++) begin
          if (word_len_r == LEN_W'(k)) word_chars_nxt[k] = c;
        end
        word_len_nxt = word_len_r + LEN_W'(1);
      end else begin
        word_ovf_nxt = 1'b1;
      end
    end

    prev_nxt = prev_mid;
    if (c == CH_NUL) prev_nxt = CLS_NONE;
    else if (is_num || c == CH_X) prev_nxt = CLS_OPERAND;
    else if (c == CH_LPAR) prev_nxt = CLS_OPEN;
    else if (c == CH_RPAR) prev_nxt = CLS_CLOSE;
    else if (is_sym) prev_nxt = CLS_OTHER;
  end

  // State registers, advance on accept
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < WORD_MAX; k++) word_chars_r[k] <= 8'h00;
      word_len_r   <= '0;
      word_ovf_r   <= 1'b0;
      held_char_r  <= 8'h00;
      held_valid_r <= 1'b0;
      prev_r       <= CLS_NONE;
    end else if (accept) begin
      word_chars_r <= word_chars_nxt;
      word_len_r   <= word_len_nxt;
      word_ovf_r   <= word_ovf_nxt;
      held_char_r  <= held_char_nxt;
      held_valid_r <= held_valid_nxt;
      prev_r       <= prev_nxt;
    end
  end

  `LEXU_ASSERT(a_push_cnt, (push |-> (push_entry.cnt != '0 && push_entry.cnt <= CNT_W'(RES_MAX))), "front pushed a bad result count")

endmodule

### hdl/lexu_queue.sv
// Short queue of result lists between front and back end.
// Depends on lexu_pkg.
`include "infix_expression_lexer_unit_defines.svh"

module lexu_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  lexu_pkg::entry_t  push_entry,
  input  logic              pop,
  output lexu_pkg::entry_t  pop_entry,
  output lexu_pkg::qstat_t  qstat
);
  import lexu_pkg::*;

  entry_t            slots_r [QDEPTH];
  logic [QAW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [QAW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] fill_r, fill_nxt;

  assign qstat.full  = fill_r == QCNT_W'(QDEPTH);
  assign qstat.empty = fill_r == '0;
  assign pop_entry   = slots_r[rd_ptr_r];

  // Advance pointers and fill count
  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + QAW'(1) : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + QAW'(1) : rd_ptr_r;
    fill_nxt   = fill_r;
    if (push && !pop) fill_nxt = fill_r + QCNT_W'(1);
    else if (pop && !push) fill_nxt = fill_r - QCNT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  // Write slot
  always_ff @(posedge clk) begin
    if (push) slots_r[wr_ptr_r] <= push_entry;
  end

  `LEXU_NEVER(a_no_overflow, (push && qstat.full), "push into full queue")
  `LEXU_NEVER(a_no_underflow, (pop && qstat.empty), "pop from empty queue")
  `LEXU_NEVER(a_fill_range, (fill_r > QCNT_W'(QDEPTH)), "queue fill count out of range")

endmodule

### hdl/lexu_back.sv
// Back end: takes result lists from the queue and sends one result per cycle,
// while out_tready allows, through the output register. Depends on lexu_pkg.
`include "infix_expression_lexer_unit_defines.svh"

module lexu_back (
  input  logic              clk,
  input  logic              rst_n,
  input  lexu_pkg::qstat_t  qstat,
  input  lexu_pkg::entry_t  pop_entry,
  output logic              pop,
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [15:0]       out_tdata,  // [4:0] token, [12:5] number_char, [13] number_end
  output logic              out_tlast   // last
);
  import lexu_pkg::*;

  entry_t            cur_r, cur_nxt;
  logic              cur_valid_r, cur_valid_nxt;
  logic [RIDX_W-1:0] idx_r, idx_nxt;
  res_t              out_res_r, out_res_nxt;
  logic              out_last_r, out_last_nxt;
  logic              out_valid_r, out_valid_nxt;

  logic out_free, emit, cur_done;

  assign out_free = !out_valid_r || out_tready;
  assign emit     = cur_valid_r && out_free;
  assign cur_done = emit && (CNT_W'(idx_r) == cur_r.cnt - CNT_W'(1));
  assign pop      = !qstat.empty && (!cur_valid_r || cur_done);

  // Step through the current list, load the next one when it is done
  always_comb begin
    cur_nxt       = cur_r;
    cur_valid_nxt = cur_valid_r;
    idx_nxt       = idx_r;
    if (pop) begin
      cur_nxt       = pop_entry;
      cur_valid_nxt = 1'b1;
      idx_nxt       = '0;
    end else if (cur_done) begin
      cur_valid_nxt = 1'b0;
    end else if (emit) begin
      idx_nxt = idx_r + RIDX_W'(1);
    end

    out_res_nxt   = out_res_r;
    out_last_nxt  = out_last_r;
    out_valid_nxt = out_valid_r;
    if (emit) begin
      out_res_nxt   = cur_r.res[idx_r];
      out_last_nxt  = cur_done;
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_valid_r <= 1'b0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      cur_valid_r <= cur_valid_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload, no reset
  always_ff @(posedge clk) begin
    cur_r      <= cur_nxt;
    out_res_r  <= out_res_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, out_res_r.nend, out_res_r.ch, out_res_r.tok};
  assign out_tlast  = out_last_r;

  `LEXU_ASSERT(a_idx_in_list, (cur_valid_r |-> (CNT_W'(idx_r) < cur_r.cnt)), "result index past end of list")

endmodule

### hdl/infix_expression_lexer_unit.sv
// Top level of the infix expression lexer: front end, result queue, back end.
// Depends on lexu_pkg, lexu_front, lexu_queue and lexu_back.
//
// Usage:
//   in_*  : one ASCII character per item in in_tdata[7:0]; character 0 ends
//           the expression and flushes a pending number or word.
//   out_* : token stream; out_tdata holds token, number_char, number_end and
//           out_tlast marks the final result caused by one input character.
//   A character that causes no result (space, word letter, first digit)
//   produces nothing on the output.
// Path: the first result of a character reaches out_tvalid via the queue
//   slot written at the accepting edge, then the list register, then the
//   output register, when the back end is idle.
// Throughput: one character per cycle while the four-entry result queue has
//   room; the back end sends one result per cycle while out_tready is high,
//   so each result that a character gives takes its own turn on the output.
// Reset: synchronous on rst_n low; clears word, number and class state and
//   empties the queue, so the next character starts a new expression.
// Stall: when out_tready is low the output holds; the queue absorbs up to four
//   characters' results, then in_tready drops until space frees up.
module infix_expression_lexer_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] character
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [4:0] token, [12:5] number_char, [13] number_end
  output logic        out_tlast   // last
);
  import lexu_pkg::*;

  qstat_t qstat;
  logic   push, pop;
  entry_t push_entry, pop_entry;

  // Classify and build result lists
  lexu_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .qstat      (qstat),
    .push       (push),
    .push_entry (push_entry)
  );

  // Decouple front and back
  lexu_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .pop_entry  (pop_entry),
    .qstat      (qstat)
  );

  // Send results one per cycle while out_tready is high
  lexu_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .qstat      (qstat),
    .pop_entry  (pop_entry),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule
